// ----- sv/linked_list_pool_manager_core_assert.svh -----
// Assertion macros shared by the pool manager RTL.
`ifndef LINKED_LIST_POOL_MANAGER_CORE_ASSERT_SVH
`define LINKED_LIST_POOL_MANAGER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/llpm_pkg.sv -----
// Package with the constants and codes of the linked-list pool manager.
package llpm_pkg;

  // Default pool depth.
  localparam int POOL_SIZE_DEF = 16;

  // Field widths.
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

endpackage

// ----- sv/llpm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module llpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/linked_list_pool_manager_core.sv -----
// Linked-list pool manager: channels, sequencer and the two node memories.
// The block keeps one singly linked list in a pool of POOL_SIZE nodes, with
// the unused nodes on a free list. Each input word carries an operation and
// a value: insert pops the free-list head, stores the value and links the
// node at the list head; remove walks from the list head to the first node
// holding the value, unlinks it and pushes it on the free list.
// Every input word gives exactly one result word (status and slot).
// Both channels use valid and stall; a result waits in an output register
// while the receiver stalls, and the sequencer then holds in its result step.
// An insert stores the value and reads the free node's link, then links the
// node at the list head; a full pool or an empty list is answered at once. A
// remove walks until a match or the list end, over at most POOL_SIZE nodes.
// The walk reads one node per cycle through the registered read port of the
// node memories, which sets the rate; one item is handled at a time, so no
// new word is accepted until the last result is in the output register.
// After reset the link memory is swept once to chain node i to node i+1,
// during which no input word is accepted.
`include "linked_list_pool_manager_core_assert.svh"

module linked_list_pool_manager_core #(
  parameter int POOL_SIZE = llpm_pkg::POOL_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic signed [llpm_pkg::VALUE_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [llpm_pkg::STATUS_W-1:0] out_status,
  output logic [llpm_pkg::SLOT_W-1:0]   out_slot
);

  import llpm_pkg::*;

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam logic [LW-1:0] NONE = LW'(POOL_SIZE);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [LW-1:0]       free_head_r, free_head_nxt;
  logic [LW-1:0]       list_head_r, list_head_nxt;
  logic [LW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [LW-1:0]       cur_r, cur_nxt;
  logic [LW-1:0]       prev_r, prev_nxt;
  logic [LW-1:0]       steps_r, steps_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [STATUS_W-1:0] resp_status_r, resp_status_nxt;
  logic [LW-1:0]       resp_slot_r, resp_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;

  logic                link_we;
  logic [IW-1:0]       link_waddr;
  logic [LW-1:0]       link_wdata;
  logic                val_we;
  logic [IW-1:0]       val_waddr;
  logic [VALUE_W-1:0]  val_wdata;
  logic [IW-1:0]       rd_addr;
  logic [LW-1:0]       link_rdata;
  logic [VALUE_W-1:0]  val_rdata;
  logic                out_free;

  // Node memories: stored values and next links.
  llpm_ram #(.WIDTH(VALUE_W), .DEPTH(POOL_SIZE)) u_value_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(val_wdata),
    .raddr(rd_addr),
    .rdata(val_rdata)
  );

  llpm_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(rd_addr),
    .rdata(link_rdata)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_free   = !out_valid_r || !out_stall;

  // Sequencer: one memory access step per cycle, holding in the result step while the output register is full.
  always_comb begin
    state_nxt       = state_r;
    free_head_nxt   = free_head_r;
    list_head_nxt   = list_head_r;
    clr_cnt_nxt     = clr_cnt_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    steps_nxt       = steps_r;
    val_nxt         = val_r;
    resp_status_nxt = resp_status_r;
    resp_slot_nxt   = resp_slot_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    link_we         = 1'b0;
    link_waddr      = cur_r[IW-1:0];
    link_wdata      = free_head_r;
    val_we          = 1'b0;
    val_waddr       = free_head_r[IW-1:0];
    val_wdata       = in_value;
    rd_addr         = cur_r[IW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        // Chain node i to node i+1 after reset.
        link_we     = 1'b1;
        link_waddr  = clr_cnt_r[IW-1:0];
        link_wdata  = LW'(clr_cnt_r + 1'b1);
        clr_cnt_nxt = LW'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == LW'(POOL_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_value;
          if (in_operation == OP_INSERT) begin
            if (free_head_r >= NONE) begin
              resp_status_nxt = ST_FULL;
              resp_slot_nxt   = '0;
              state_nxt       = S_RESP;
            end else begin
              // Store the value now and fetch the free node's link.
              val_we    = 1'b1;
              val_waddr = free_head_r[IW-1:0];
              rd_addr   = free_head_r[IW-1:0];
              cur_nxt   = free_head_r;
              state_nxt = S_INS;
            end
          end else begin
            if (list_head_r >= NONE) begin
              resp_status_nxt = ST_MISSING;
              resp_slot_nxt   = '0;
              state_nxt       = S_RESP;
            end else begin
              rd_addr   = list_head_r[IW-1:0];
              cur_nxt   = list_head_r;
              prev_nxt  = NONE;
              steps_nxt = '0;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_INS: begin
        // Pop the free list and link the node at the list head.
        free_head_nxt   = link_rdata;
        link_we         = 1'b1;
        link_waddr      = cur_r[IW-1:0];
        link_wdata      = list_head_r;
        list_head_nxt   = cur_r;
        resp_status_nxt = ST_DONE;
        resp_slot_nxt   = cur_r;
        state_nxt       = S_RESP;
      end
      S_WALK: begin
        if (val_rdata == val_r) begin
          // Match: bypass the node from its predecessor or the head.
          if (prev_r >= NONE) begin
            list_head_nxt = link_rdata;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_r[IW-1:0];
            link_wdata = link_rdata;
          end
          state_nxt = S_FREE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rdata;
          steps_nxt = LW'(steps_r + 1'b1);
          rd_addr   = link_rdata[IW-1:0];
          if (link_rdata >= NONE || LW'(steps_r + 1'b1) == NONE) begin
            resp_status_nxt = ST_MISSING;
            resp_slot_nxt   = '0;
            state_nxt       = S_RESP;
          end
        end
      end
      S_FREE: begin
        // Push the unlinked node onto the free list.
        link_we         = 1'b1;
        link_waddr      = cur_r[IW-1:0];
        link_wdata      = free_head_r;
        free_head_nxt   = cur_r;
        resp_status_nxt = ST_DONE;
        resp_slot_nxt   = cur_r;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        // Hand the result word to the output register once it is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_slot_nxt   = SLOT_W'(resp_slot_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      free_head_r <= '0;
      list_head_r <= NONE;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      list_head_r <= list_head_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    steps_r       <= steps_nxt;
    val_r         <= val_nxt;
    resp_status_r <= resp_status_nxt;
    resp_slot_r   <= resp_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
  end

  // A result that is not done always carries slot zero.
  `LLPM_ASSERT_NOW(a_slot_zero, clk, rst_n,
    out_valid_r && out_status_r != ST_DONE, out_slot_r == '0,
    "result without done status has a nonzero slot")

  // An accepted word keeps the block busy in the next cycle.
  `LLPM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
    in_valid && !in_stall, state_r != S_IDLE,
    "block idle right after accepting a word")

  // A node is never at the head of both lists.
  `LLPM_ASSERT_NOW(a_heads_differ, clk, rst_n,
    free_head_r < NONE && list_head_r < NONE, free_head_r != list_head_r,
    "free list and node list share a head")

endmodule
